>>> rtl/stsd_pkg.sv
// ----------------------------------------------------------------------------
// stsd_pkg
// Shared constants, shape codes and fixed-point helpers for the sphere to
// shape distance pipeline.
// ----------------------------------------------------------------------------
package stsd_pkg;

	localparam int CB        = 16;
	localparam int AXIS_FRAC = CB - 2;
	localparam int FIELD_W   = 3 * CB;

	localparam int R_W  = CB + 9;
	localparam int D_W  = CB + 8;
	localparam int RZ_W = R_W + CB;
	localparam int CP_W = 2 * CB;
	localparam int T_W  = R_W + 6;
	localparam int TZ_W = T_W + CB;
	localparam int P_W  = T_W + 3;
	localparam int PX_W = P_W + CB;
	localparam int M_W  = CB + D_W;
	localparam int V_W  = 28;
	localparam int SUM_W = 2 * V_W;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int SQRT_ITER = 4;
	localparam int SQRT_STAGES = ROOT_W / SQRT_ITER;
	localparam int NUM_STAGES = 12 + SQRT_STAGES;

	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic signed [63:0] LEN_LIMIT = 64'sd1 <<< 26;

	typedef enum logic [1:0] {
		SHAPE_SPHERE     = 2'd0,
		SHAPE_PLATE      = 2'd1,
		SHAPE_PLATE_HOLE = 2'd2,
		SHAPE_CYLINDER   = 2'd3
	} shape_t;

	// shift down by the axis fraction, rounding half away from zero
	function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? -v : v;
		r = (mag + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic logic signed [CB-1:0] sat_comp(input logic signed [63:0] v);
		logic signed [63:0] amax;
		amax = (64'sd1 <<< (CB - 1)) - 64'sd1;
		if (v > amax)
			return CB'(amax);
		if (v < -amax - 64'sd1)
			return CB'(-amax - 64'sd1);
		return CB'(v);
	endfunction

endpackage

>>> rtl/stsd_isqrt.sv
// ----------------------------------------------------------------------------
// stsd_isqrt
// Pipelined integer square root, restoring digit-by-digit form, a fixed
// number of root bits per stage. Stage loads come from the top level.
// ----------------------------------------------------------------------------
module stsd_isqrt (
	input  logic                                clk,
	input  logic [stsd_pkg::SQRT_STAGES-1:0]    ld,
	input  logic [stsd_pkg::SUM_W-1:0]          radicand,
	output logic [stsd_pkg::ROOT_W-1:0]         root
);
	import stsd_pkg::*;

	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];
	logic [SUM_W-1:0]  rest_s [SQRT_STAGES];

	logic [REM_W-1:0]  rem_nx  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_nx [SQRT_STAGES];
	logic [SUM_W-1:0]  rest_nx [SQRT_STAGES];

	always_comb begin
		logic [REM_W-1:0]  rm;
		logic [ROOT_W-1:0] rt;
		logic [SUM_W-1:0]  rs;
		logic [REM_W+1:0]  rx;
		logic [REM_W+1:0]  trial;
		for (int j = 0; j < SQRT_STAGES; j++) begin
			if (j == 0) begin
				rm = '0;
				rt = '0;
				rs = radicand;
			end else begin
				rm = rem_s[j-1];
				rt = root_s[j-1];
				rs = rest_s[j-1];
			end
			for (int k = 0; k < SQRT_ITER; k++) begin
				rx = {rm, rs[SUM_W-1 -: 2]};
				trial = (REM_W + 2)'({rt, 2'b01});
				rs = rs << 2;
				if (rx >= trial) begin
					rm = REM_W'(rx - trial);
					rt = {rt[ROOT_W-2:0], 1'b1};
				end else begin
					rm = REM_W'(rx);
					rt = {rt[ROOT_W-2:0], 1'b0};
				end
			end
			rem_nx[j]  = rm;
			root_nx[j] = rt;
			rest_nx[j] = rs;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SQRT_STAGES; j++) begin
			if (ld[j]) begin
				rem_s[j]  <= rem_nx[j];
				root_s[j] <= root_nx[j];
				rest_s[j] <= rest_nx[j];
			end
		end
	end

	assign root = root_s[SQRT_STAGES-1];

endmodule

>>> rtl/sphere_to_shape_distance.sv
// ----------------------------------------------------------------------------
// sphere_to_shape_distance
// Distance from a sphere center to a sphere, plate or cylinder, Q10.8 out.
//
//   channel   signals                        direction
//   item      item_valid/item_stall, fields  in
//   result    result_valid/result_stall      out
//
// One pair per cycle while result_stall is low (11 geometry stages, 7 square root
// stages of 4 root bits each, one output register).
// Reset clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so a
// stall fills bubbles and then holds every transfer in place.
// ----------------------------------------------------------------------------
module sphere_to_shape_distance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    shape_a,
	input  logic [1:0]                    shape_b,
	input  logic [stsd_pkg::FIELD_W-1:0]  center_a,
	input  logic [stsd_pkg::FIELD_W-1:0]  axis_z_a,
	input  logic [stsd_pkg::FIELD_W-1:0]  axis_x_a,
	input  logic [stsd_pkg::FIELD_W-1:0]  extent_a,
	input  logic [stsd_pkg::FIELD_W-1:0]  center_b,
	input  logic [stsd_pkg::FIELD_W-1:0]  axis_z_b,
	input  logic [stsd_pkg::FIELD_W-1:0]  axis_x_b,
	input  logic [stsd_pkg::FIELD_W-1:0]  extent_b,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [stsd_pkg::DIST_W-1:0]   distance,
	output logic                          unsupported
);
	import stsd_pkg::*;

	logic [NUM_STAGES+1:1] rdy;
	logic [NUM_STAGES:1]   vld_q;

	always_comb begin
		rdy[NUM_STAGES+1] = !result_stall;
		for (int k = NUM_STAGES; k >= 1; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign item_stall   = !rdy[1];
	assign result_valid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1])
				vld_q[1] <= item_valid;
			for (int k = 2; k <= NUM_STAGES; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// pair ordering: lower shape code is the sphere
	logic                swap;
	logic [1:0]          lo_shape, hi_shape;
	logic [FIELD_W-1:0]  sc, oc, oz, ox, oe;

	always_comb begin
		swap     = shape_a > shape_b;
		lo_shape = swap ? shape_b : shape_a;
		hi_shape = swap ? shape_a : shape_b;
		sc = swap ? center_b : center_a;
		oc = swap ? center_a : center_b;
		oz = swap ? axis_z_a : axis_z_b;
		ox = swap ? axis_x_a : axis_x_b;
		oe = swap ? extent_a : extent_b;
	end

	// stage 1
	logic                 unsup_s1;
	shape_t               kind_s1;
	logic signed [R_W-1:0] r_s1 [3];
	logic signed [CB-1:0]  z_s1 [3];
	logic signed [CB-1:0]  x_s1 [3];
	logic signed [D_W-1:0] hw_s1, hl_s1, hh_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			unsup_s1 <= lo_shape != SHAPE_SPHERE;
			kind_s1  <= shape_t'(hi_shape);
			for (int i = 0; i < 3; i++) begin
				r_s1[i] <= (R_W'($signed(sc[i*CB +: CB])) - R_W'($signed(oc[i*CB +: CB])))
					<<< 8;
				z_s1[i] <= oz[i*CB +: CB];
				x_s1[i] <= ox[i*CB +: CB];
			end
			hw_s1 <= {1'b0, oe[0 +: CB], 7'd0};
			hl_s1 <= {1'b0, oe[CB +: CB], 7'd0};
			hh_s1 <= {1'b0, oe[2*CB +: CB], 7'd0};
		end
	end

	// stage 2: r.z products, cross product terms
	logic                   unsup_s2;
	shape_t                 kind_s2;
	logic signed [R_W-1:0]  r_s2 [3];
	logic signed [CB-1:0]   z_s2 [3];
	logic signed [CB-1:0]   x_s2 [3];
	logic signed [D_W-1:0]  hw_s2, hl_s2, hh_s2;
	logic signed [RZ_W-1:0] rz_s2 [3];
	logic signed [CP_W-1:0] cp_s2 [3];
	logic signed [CP_W-1:0] cn_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			unsup_s2 <= unsup_s1;
			kind_s2  <= kind_s1;
			hw_s2 <= hw_s1;
			hl_s2 <= hl_s1;
			hh_s2 <= hh_s1;
			for (int i = 0; i < 3; i++) begin
				r_s2[i]  <= r_s1[i];
				z_s2[i]  <= z_s1[i];
				x_s2[i]  <= x_s1[i];
				rz_s2[i] <= RZ_W'(r_s1[i]) * RZ_W'(z_s1[i]);
			end
			cp_s2[0] <= CP_W'(z_s1[1]) * CP_W'(x_s1[2]);
			cn_s2[0] <= CP_W'(z_s1[2]) * CP_W'(x_s1[1]);
			cp_s2[1] <= CP_W'(z_s1[2]) * CP_W'(x_s1[0]);
			cn_s2[1] <= CP_W'(z_s1[0]) * CP_W'(x_s1[2]);
			cp_s2[2] <= CP_W'(z_s1[0]) * CP_W'(x_s1[1]);
			cn_s2[2] <= CP_W'(z_s1[1]) * CP_W'(x_s1[0]);
		end
	end

	// stage 3: axial coordinate t, y axis
	logic                  unsup_s3;
	shape_t                kind_s3;
	logic signed [R_W-1:0] r_s3 [3];
	logic signed [CB-1:0]  z_s3 [3];
	logic signed [CB-1:0]  x_s3 [3];
	logic signed [CB-1:0]  y_s3 [3];
	logic signed [D_W-1:0] hw_s3, hl_s3, hh_s3;
	logic signed [T_W-1:0] t_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			unsup_s3 <= unsup_s2;
			kind_s3  <= kind_s2;
			hw_s3 <= hw_s2;
			hl_s3 <= hl_s2;
			hh_s3 <= hh_s2;
			t_s3  <= T_W'(rnd_frac(64'(rz_s2[0]) + 64'(rz_s2[1]) + 64'(rz_s2[2])));
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= r_s2[i];
				z_s3[i] <= z_s2[i];
				x_s3[i] <= x_s2[i];
				y_s3[i] <= sat_comp(rnd_frac(64'(cp_s2[i]) - 64'(cn_s2[i])));
			end
		end
	end

	// stage 4: t*z, cylinder clamp
	logic                   unsup_s4;
	shape_t                 kind_s4;
	logic signed [R_W-1:0]  r_s4 [3];
	logic signed [CB-1:0]   z_s4 [3];
	logic signed [CB-1:0]   x_s4 [3];
	logic signed [CB-1:0]   y_s4 [3];
	logic signed [D_W-1:0]  hw_s4, hl_s4, sc_s4;
	logic signed [TZ_W-1:0] tz_s4 [3];

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			unsup_s4 <= unsup_s3;
			kind_s4  <= kind_s3;
			hw_s4 <= hw_s3;
			hl_s4 <= hl_s3;
			sc_s4 <= D_W'(clamp_sym(64'(t_s3), 64'(hh_s3)));
			for (int i = 0; i < 3; i++) begin
				r_s4[i]  <= r_s3[i];
				z_s4[i]  <= z_s3[i];
				x_s4[i]  <= x_s3[i];
				y_s4[i]  <= y_s3[i];
				tz_s4[i] <= TZ_W'(t_s3) * TZ_W'(z_s3[i]);
			end
		end
	end

	// stage 5: projection onto plate plane
	logic                  unsup_s5;
	shape_t                kind_s5;
	logic signed [R_W-1:0] r_s5 [3];
	logic signed [CB-1:0]  z_s5 [3];
	logic signed [CB-1:0]  x_s5 [3];
	logic signed [CB-1:0]  y_s5 [3];
	logic signed [D_W-1:0] hw_s5, hl_s5, sc_s5;
	logic signed [P_W-1:0] p_s5 [3];

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			unsup_s5 <= unsup_s4;
			kind_s5  <= kind_s4;
			hw_s5 <= hw_s4;
			hl_s5 <= hl_s4;
			sc_s5 <= sc_s4;
			for (int i = 0; i < 3; i++) begin
				r_s5[i] <= r_s4[i];
				z_s5[i] <= z_s4[i];
				x_s5[i] <= x_s4[i];
				y_s5[i] <= y_s4[i];
				p_s5[i] <= P_W'(64'(r_s4[i]) - rnd_frac(64'(tz_s4[i])));
			end
		end
	end

	// stage 6: p.x and p.y products
	logic                   unsup_s6;
	shape_t                 kind_s6;
	logic signed [R_W-1:0]  r_s6 [3];
	logic signed [CB-1:0]   z_s6 [3];
	logic signed [CB-1:0]   x_s6 [3];
	logic signed [CB-1:0]   y_s6 [3];
	logic signed [D_W-1:0]  hw_s6, hl_s6, sc_s6;
	logic signed [PX_W-1:0] px_s6 [3];
	logic signed [PX_W-1:0] py_s6 [3];

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			unsup_s6 <= unsup_s5;
			kind_s6  <= kind_s5;
			hw_s6 <= hw_s5;
			hl_s6 <= hl_s5;
			sc_s6 <= sc_s5;
			for (int i = 0; i < 3; i++) begin
				r_s6[i]  <= r_s5[i];
				z_s6[i]  <= z_s5[i];
				x_s6[i]  <= x_s5[i];
				y_s6[i]  <= y_s5[i];
				px_s6[i] <= PX_W'(p_s5[i]) * PX_W'(x_s5[i]);
				py_s6[i] <= PX_W'(p_s5[i]) * PX_W'(y_s5[i]);
			end
		end
	end

	// stage 7: in-plane clamp and per-shape operand select
	logic signed [D_W-1:0] dx, dy;
	logic signed [D_W-1:0] d1_nx, d2_nx;
	logic signed [CB-1:0]  u1_nx [3];

	always_comb begin
		dx = D_W'(clamp_sym(rnd_frac(64'(px_s6[0]) + 64'(px_s6[1]) + 64'(px_s6[2])),
			64'(hw_s6)));
		dy = D_W'(clamp_sym(rnd_frac(64'(py_s6[0]) + 64'(py_s6[1]) + 64'(py_s6[2])),
			64'(hl_s6)));
		u1_nx = x_s6;
		case (kind_s6)
			SHAPE_PLATE, SHAPE_PLATE_HOLE: begin
				d1_nx = dx;
				d2_nx = dy;
			end
			SHAPE_CYLINDER: begin
				u1_nx = z_s6;
				d1_nx = sc_s6;
				d2_nx = '0;
			end
			default: begin
				d1_nx = '0;
				d2_nx = '0;
			end
		endcase
	end

	logic                  unsup_s7;
	logic signed [R_W-1:0] r_s7 [3];
	logic signed [CB-1:0]  u1_s7 [3];
	logic signed [CB-1:0]  u2_s7 [3];
	logic signed [D_W-1:0] d1_s7, d2_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			unsup_s7 <= unsup_s6;
			d1_s7 <= d1_nx;
			d2_s7 <= d2_nx;
			for (int i = 0; i < 3; i++) begin
				r_s7[i]  <= r_s6[i];
				u1_s7[i] <= u1_nx[i];
				u2_s7[i] <= y_s6[i];
			end
		end
	end

	// stage 8: closest point terms
	logic                  unsup_s8;
	logic signed [R_W-1:0] r_s8 [3];
	logic signed [M_W-1:0] m1_s8 [3];
	logic signed [M_W-1:0] m2_s8 [3];

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			unsup_s8 <= unsup_s7;
			for (int i = 0; i < 3; i++) begin
				r_s8[i]  <= r_s7[i];
				m1_s8[i] <= M_W'(u1_s7[i]) * M_W'(d1_s7);
				m2_s8[i] <= M_W'(u2_s7[i]) * M_W'(d2_s7);
			end
		end
	end

	// stage 9: difference vector
	logic signed [63:0] vt [3];
	logic               big_nx;

	always_comb begin
		big_nx = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vt[i] = rnd_frac(64'(m1_s8[i])) + rnd_frac(64'(m2_s8[i])) - 64'(r_s8[i]);
			if (vt[i] >= LEN_LIMIT || vt[i] <= -LEN_LIMIT)
				big_nx = 1'b1;
		end
	end

	logic                  unsup_s9, big_s9;
	logic signed [V_W-1:0] v_s9 [3];

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			unsup_s9 <= unsup_s8;
			big_s9   <= big_nx;
			for (int i = 0; i < 3; i++)
				v_s9[i] <= V_W'(vt[i]);
		end
	end

	// stage 10: squares
	logic                    unsup_s10, big_s10;
	logic signed [SUM_W-1:0] sq_s10 [3];

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			unsup_s10 <= unsup_s9;
			big_s10   <= big_s9;
			for (int i = 0; i < 3; i++)
				sq_s10[i] <= SUM_W'(v_s9[i]) * SUM_W'(v_s9[i]);
		end
	end

	// stage 11: sum of squares
	logic             unsup_s11, big_s11;
	logic [SUM_W-1:0] ssum_s11;

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			unsup_s11 <= unsup_s10;
			big_s11   <= big_s10;
			ssum_s11  <= SUM_W'(sq_s10[0] + sq_s10[1] + sq_s10[2]);
		end
	end

	// square root stages
	logic [ROOT_W-1:0] root;
	logic              unsup_sq [SQRT_STAGES];
	logic              big_sq   [SQRT_STAGES];

	stsd_isqrt u_isqrt (
		.clk      (clk),
		.ld       (rdy[11+SQRT_STAGES:12]),
		.radicand (ssum_s11),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			unsup_sq[0] <= unsup_s11;
			big_sq[0]   <= big_s11;
		end
		for (int j = 1; j < SQRT_STAGES; j++) begin
			if (rdy[12+j]) begin
				unsup_sq[j] <= unsup_sq[j-1];
				big_sq[j]   <= big_sq[j-1];
			end
		end
	end

	// output register: round to 8 fraction bits, saturate
	logic [ROOT_W:0]     lr;
	logic [ROOT_W-8:0]   len;
	logic [DIST_W-1:0]   dist_nx;

	always_comb begin
		lr  = (ROOT_W + 1)'(root) + (ROOT_W + 1)'(128);
		len = lr[ROOT_W:8];
		if (big_sq[SQRT_STAGES-1] || len > (ROOT_W - 7)'(DIST_MAX))
			dist_nx = DIST_MAX;
		else
			dist_nx = DIST_W'(len);
		if (unsup_sq[SQRT_STAGES-1])
			dist_nx = '0;
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_STAGES]) begin
			distance    <= dist_nx;
			unsupported <= unsup_sq[SQRT_STAGES-1];
		end
	end

endmodule

>>> tb/tb_sphere_to_shape_distance.sv
// ----------------------------------------------------------------------------
// tb_sphere_to_shape_distance
// Drives body pairs through the distance pipeline with random gaps and
// stalls, predicts each distance in fixed point and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sphere_to_shape_distance;
	import stsd_pkg::*;

	typedef struct {
		logic [1:0]         sa, sb;
		logic [FIELD_W-1:0] ca, za, xa, ea, cb, zb, xb, eb;
	} pair_t;

	typedef struct {
		logic [DIST_W-1:0] dval;
		logic              unsup;
	} dist_t;

	logic clk = 0, arst_n = 0;
	logic item_valid = 0, item_stall, result_valid, result_stall = 1;
	logic [1:0] shape_a = 0, shape_b = 0;
	logic [FIELD_W-1:0] center_a = 0, axis_z_a = 0, axis_x_a = 0, extent_a = 0;
	logic [FIELD_W-1:0] center_b = 0, axis_z_b = 0, axis_x_b = 0, extent_b = 0;
	logic [DIST_W-1:0] distance;
	logic unsupported;

	pair_t pending[$];
	dist_t expected_dist[$];
	int    errors = 0;
	bit    feed_done = 0;
	int    send_gap = 0, recv_gap = 0, hold_cnt = 0;
	bit    hold_done = 0;

	sphere_to_shape_distance u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint comp(logic [FIELD_W-1:0] w, int i);
		logic signed [CB-1:0] c;
		c = w[i*CB +: CB];
		return c;
	endfunction

	function automatic longint ucomp(logic [FIELD_W-1:0] w, int i);
		return longint'(w[i*CB +: CB]);
	endfunction

	function automatic longint rshift(longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (AXIS_FRAC - 1))) >>> AXIS_FRAC;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint isqrt(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic dist_t predict_distance(pair_t p);
		dist_t o;
		logic [1:0] s0, s1;
		logic [FIELD_W-1:0] sc, oc, oz, ox, oe;
		longint r[3], z[3], x[3], y[3], v[3], pp[3];
		longint t, dx, dy, hw, hl, hh, d, s, amax, l;
		longint unsigned sum;
		s0 = p.sa; s1 = p.sb;
		sc = p.ca; oc = p.cb; oz = p.zb; ox = p.xb; oe = p.eb;
		if (s0 > s1) begin
			s0 = p.sb; s1 = p.sa;
			sc = p.cb; oc = p.ca; oz = p.za; ox = p.xa; oe = p.ea;
		end
		o.dval = 0;
		o.unsup = 1;
		if (s0 != SHAPE_SPHERE) return o;
		o.unsup = 0;
		amax = (64'sd1 <<< (CB - 1)) - 1;
		for (int i = 0; i < 3; i++) begin
			r[i] = (comp(sc, i) - comp(oc, i)) * 256;
			z[i] = comp(oz, i);
			x[i] = comp(ox, i);
		end
		if (s1 == SHAPE_SPHERE) begin
			for (int i = 0; i < 3; i++) v[i] = r[i];
		end else if (s1 == SHAPE_PLATE || s1 == SHAPE_PLATE_HOLE) begin
			hw = ucomp(oe, 0) * 128;
			hl = ucomp(oe, 1) * 128;
			y[0] = rshift(z[1] * x[2] - z[2] * x[1]);
			y[1] = rshift(z[2] * x[0] - z[0] * x[2]);
			y[2] = rshift(z[0] * x[1] - z[1] * x[0]);
			for (int i = 0; i < 3; i++) begin
				if (y[i] > amax) y[i] = amax;
				if (y[i] < -amax - 1) y[i] = -amax - 1;
			end
			t = rshift(r[0] * z[0] + r[1] * z[1] + r[2] * z[2]);
			for (int i = 0; i < 3; i++) pp[i] = r[i] - rshift(t * z[i]);
			dx = rshift(pp[0] * x[0] + pp[1] * x[1] + pp[2] * x[2]);
			dy = rshift(pp[0] * y[0] + pp[1] * y[1] + pp[2] * y[2]);
			dx = dx < -hw ? -hw : (dx > hw ? hw : dx);
			dy = dy < -hl ? -hl : (dy > hl ? hl : dy);
			for (int i = 0; i < 3; i++)
				v[i] = rshift(x[i] * dx) + rshift(y[i] * dy) - r[i];
		end else begin
			hh = ucomp(oe, 2) * 128;
			d = rshift(r[0] * z[0] + r[1] * z[1] + r[2] * z[2]);
			if (d < hh && d > -hh) s = d;
			else if (d >= hh) s = hh;
			else s = -hh;
			for (int i = 0; i < 3; i++) v[i] = rshift(z[i] * s) - r[i];
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (v[i] >= (64'sd1 <<< 26) || v[i] <= -(64'sd1 <<< 26)) begin
				o.dval = DIST_MAX;
				return o;
			end
			sum += v[i] * v[i];
		end
		l = (isqrt(sum) + 128) >> 8;
		o.dval = l > 262143 ? DIST_MAX : DIST_W'(l);
		return o;
	endfunction

	function automatic int gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
	endfunction

	function automatic logic [FIELD_W-1:0] rnd48();
		return FIELD_W'({$urandom, $urandom});
	endfunction

	// random axis: each component uniform in -16384..16384, not normalised
	function automatic logic [FIELD_W-1:0] rnd_axis();
		logic [FIELD_W-1:0] w;
		for (int i = 0; i < 3; i++)
			w[i*CB +: CB] = CB'($signed($urandom_range(0, 32768)) - 16384);
		return w;
	endfunction

	function automatic logic [FIELD_W-1:0] rnd_pos();
		logic [FIELD_W-1:0] w;
		for (int i = 0; i < 3; i++)
			w[i*CB +: CB] = CB'($signed($urandom_range(0, 8191)) - 4096);
		return w;
	endfunction

	function automatic pair_t rnd_pair();
		pair_t p;
		p.sa = 2'($urandom); p.sb = 2'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			if ($urandom_range(0, 1)) p.sa = SHAPE_SPHERE; else p.sb = SHAPE_SPHERE;
			p.ca = rnd_pos(); p.cb = rnd_pos();
			p.za = rnd_axis(); p.zb = rnd_axis();
			p.xa = rnd_axis(); p.xb = rnd_axis();
			p.ea = rnd48() & 48'h0FFF_0FFF_0FFF; p.eb = rnd48() & 48'h0FFF_0FFF_0FFF;
		end else begin
			p.ca = rnd48(); p.cb = rnd48(); p.za = rnd48(); p.zb = rnd48();
			p.xa = rnd48(); p.xb = rnd48(); p.ea = rnd48(); p.eb = rnd48();
		end
		return p;
	endfunction

	initial begin
		pair_t p;
		logic [FIELD_W-1:0] ez, ex, pmax, nmax;
		ez = {16'h0, 16'h0, 16'h4000};
		ex = {16'h0, 16'h4000, 16'h0};
		pmax = {3{16'h7FFF}};
		nmax = {3{16'h8000}};
		for (int s = 0; s < 16; s++) begin
			p = rnd_pair();
			p.sa = s[1:0]; p.sb = s[3:2];
			p.za = ez; p.xa = ex; p.zb = ez; p.xb = ex;
			pending.push_back(p);
		end
		p = rnd_pair(); p.sa = SHAPE_SPHERE; p.sb = SHAPE_SPHERE;
		p.ca = pmax; p.cb = nmax; pending.push_back(p);
		p.sb = SHAPE_PLATE; p.zb = pmax; p.xb = nmax; p.eb = '1; pending.push_back(p);
		p.sb = SHAPE_CYLINDER; p.zb = nmax; p.eb = 0; pending.push_back(p);
		p.ca = 0; p.cb = 0; p.zb = ez; pending.push_back(p);
		p.sb = SHAPE_PLATE_HOLE; p.ca = 0; p.cb = '1; p.eb = 0; pending.push_back(p);
		p.sa = SHAPE_CYLINDER; p.sb = SHAPE_SPHERE; p.ea = '1; p.cb = pmax;
		pending.push_back(p);
		for (int i = 0; i < 1000; i++) pending.push_back(rnd_pair());
		feed_done = 1;
	end

	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			expected_dist.push_back(predict_distance('{shape_a, shape_b, center_a,
				axis_z_a, axis_x_a, extent_a, center_b, axis_z_b, axis_x_b, extent_b}));
		end
		if (arst_n && (!item_valid || !item_stall)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 0;
			end else if (pending.size() > 0) begin
				pair_t q;
				q = pending.pop_front();
				shape_a <= q.sa; shape_b <= q.sb;
				center_a <= q.ca; axis_z_a <= q.za; axis_x_a <= q.xa; extent_a <= q.ea;
				center_b <= q.cb; axis_z_b <= q.zb; axis_x_b <= q.xb; extent_b <= q.eb;
				item_valid <= 1;
				send_gap <= gap();
			end else
				item_valid <= 0;
		end
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (expected_dist.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer: %0d %0b", distance, unsupported);
			end else begin
				dist_t e;
				e = expected_dist.pop_front();
				if (e.dval !== distance || e.unsup !== unsupported) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0d/%0b got %0d/%0b",
							e.dval, e.unsup, distance, unsupported);
				end
			end
		end
		if (arst_n) begin
			if (!hold_done && expected_dist.size() > 4) begin
				result_stall <= 1;
				hold_cnt <= hold_cnt + 1;
				if (hold_cnt == 80) hold_done <= 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				result_stall <= 1;
			end else begin
				result_stall <= 0;
				recv_gap <= ($urandom_range(0, 3) == 0) ? gap() : 0;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		wait (feed_done);
		while (pending.size() > 0 || item_valid || expected_dist.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
